>>> rtl/bcc_pkg.sv
// Shared types, codes and constants for the battery coulomb counter.
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  // Item selector codes
  localparam logic [1:0] FUNC_SAMPLE   = 2'd0;
  localparam logic [1:0] FUNC_LOAD_MAH = 2'd1;
  localparam logic [1:0] FUNC_LOAD_PCT = 2'd2;
  localparam logic [1:0] FUNC_NONE     = 2'd3;

  // Configuration register indexes
  localparam int          CFG_IDX_W = 2;
  localparam int          CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_CURRENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_PER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_CHARGE = 2'd2;

  // Register reset values
  localparam logic signed [15:0] ZERO_CURRENT_RESET = 16'sd512;
  localparam logic [15:0]        CHARGE_PER_COUNT_RESET = 16'd1000;
  localparam logic [15:0]        FULL_CHARGE_RESET = 16'd5000;
  localparam logic [15:0]        CHARGE_RESET = 16'd3000;

  // Datapath widths
  localparam int MUL_W  = 17;          // signed multiplier operand
  localparam int PROD_W = 2 * MUL_W;   // signed product
  localparam int SUM_W  = PROD_W + 1;  // residue plus product
  localparam int RES_W  = 23;          // residue, within +/- one mAh in uC
  localparam int DVD_W  = PROD_W;      // dividend and quotient
  localparam int DVSR_W = 22;          // widest divisor
  localparam int REM_W  = DVSR_W + 1;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W  = $clog2(DIV_STEPS);

  // Reciprocal division by the fixed divisors
  localparam int QMAH_W     = 11;      // whole mAh steps in one sample
  localparam int MAH_PRE_SH = 7;       // 3600000 = 2^7 * 28125
  localparam int MAH_X_W    = DVD_W - MAH_PRE_SH;
  localparam int RCP_MAH_W  = 27;
  localparam int RCP_MAH_SH = 41;
  localparam logic [RCP_MAH_W-1:0] RCP_MAH = 27'd78187494;  // ceil(2^41 / 28125)
  localparam int QLD_W      = 17;      // loaded charge before saturation
  localparam int PCT_PRE_SH = 2;       // 100 = 2^2 * 25
  localparam int LD_X_W     = 21;
  localparam int RCP_PCT_W  = 22;
  localparam int RCP_PCT_SH = 26;
  localparam logic [RCP_PCT_W-1:0] RCP_PCT = 22'd2684355;   // ceil(2^26 / 25)

  // Arithmetic constants
  localparam logic [DVSR_W-1:0] MAH_IN_UC = 22'd3600000;
  localparam logic [DVSR_W-1:0] PCT_SCALE = 22'd100;
  localparam logic [15:0]       CHARGE_MAX = 16'hFFFF;
  localparam logic [7:0]        PERCENT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] adc_counts;
    logic [15:0]        new_charge_mah;
    logic [6:0]         new_percent;
  } bcc_in_t;

  typedef struct packed {
    logic [15:0] charge_mah;
    logic [7:0]  percent;
  } bcc_out_t;

  typedef enum logic [1:0] {
    MUL_SAMPLE,
    MUL_LOAD,
    MUL_PCT
  } mul_sel_t;

  typedef enum logic [1:0] {
    DIV_RESIDUE,
    DIV_LOAD,
    DIV_PCT
  } div_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     add_res;
    logic     div_load;
    logic     div_step;
    div_sel_t div_sel;
    logic     rem_mah;
    logic     apply_residue;
    logic     apply_load;
    logic     apply_mah;
    logic     pct_full_zero;
    logic     apply_pct;
    logic     out_write;
  } bcc_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       full_zero;
    logic       out_busy;
  } bcc_status_t;

endpackage

`default_nettype wire

>>> rtl/bcc_datapath.sv
// Datapath: configuration, charge and residue state, shared multiplier and divider.
`timescale 1ns / 1ps
`default_nettype none

module bcc_datapath
  import bcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire bcc_in_t              in_data,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output bcc_out_t                  out_data,
  input  wire bcc_cmd_t             cmd,
  output bcc_status_t               status
);

  // Configuration registers
  logic signed [15:0] zero_current;
  logic [15:0]        charge_per_count;
  logic [15:0]        full_charge;

  // Latched item
  logic [1:0]         func;
  logic signed [16:0] delta;
  logic [15:0]        new_charge;
  logic [6:0]         new_percent;

  // State
  logic [15:0]              charge;
  logic signed [RES_W-1:0]  residue;
  logic [7:0]               percent;

  // Arithmetic
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] product;
  logic signed [SUM_W-1:0]  res_sum;
  logic [SUM_W-1:0]         res_mag_m1;
  logic [DVD_W-1:0]         mag_m1;
  logic                     res_neg;
  logic                     res_zero;
  logic [DVD_W-1:0]         dvd;
  logic [REM_W-1:0]         rem;
  logic [DVSR_W-1:0]        dvsr;
  logic [REM_W-1:0]         trial;
  logic                     trial_ge;
  logic [RES_W-1:0]         rem_p1;
  logic [DVD_W:0]           charge_sum;

  // Fixed divisions
  logic [MAH_X_W-1:0]              mah_x;
  logic [MAH_X_W+RCP_MAH_W-1:0]    mah_recip;
  logic [QMAH_W-1:0]               mah_steps;
  logic [QMAH_W+DVSR_W-1:0]        mah_taken;
  logic [DVD_W-1:0]                mah_left;
  logic [LD_X_W-1:0]               ld_x;
  logic [LD_X_W+RCP_PCT_W-1:0]     ld_recip;
  logic [QLD_W-1:0]                ld_quot;

  // Write configuration registers; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_current     <= ZERO_CURRENT_RESET;
      charge_per_count <= CHARGE_PER_COUNT_RESET;
      full_charge      <= FULL_CHARGE_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_ZERO_CURRENT:     zero_current     <= cfg_data;
        REG_CHARGE_PER_COUNT: charge_per_count <= cfg_data;
        REG_FULL_CHARGE:      full_charge      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the item and its offset-corrected reading
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func        <= in_data.func;
      delta       <= 17'(in_data.adc_counts) - 17'(zero_current);
      new_charge  <= in_data.new_charge_mah;
      new_percent <= in_data.new_percent;
    end
  end

  // Select multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SAMPLE: begin
        mul_a = delta;
        mul_b = $signed({1'b0, charge_per_count});
      end
      MUL_LOAD: begin
        mul_a = $signed({10'd0, new_percent});
        mul_b = $signed({1'b0, full_charge});
      end
      MUL_PCT: begin
        mul_a = $signed({1'b0, charge});
        mul_b = $signed(MUL_W'(PCT_SCALE));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      product <= mul_a * mul_b;
    end
  end

  // Add the sample charge to the residue and take its magnitude minus one
  assign res_sum    = SUM_W'(residue) + SUM_W'(product);
  assign res_mag_m1 = (res_sum[SUM_W-1] ? SUM_W'(-res_sum) : SUM_W'(res_sum)) - SUM_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.add_res) begin
      res_neg  <= res_sum[SUM_W-1];
      res_zero <= (res_sum == '0);
      mag_m1   <= res_mag_m1[DVD_W-1:0];
    end
  end

  // Whole mAh in the residue: drop the power-of-two factor, then multiply by the reciprocal
  assign mah_x     = mag_m1[DVD_W-1:MAH_PRE_SH];
  assign mah_recip = {{RCP_MAH_W{1'b0}}, mah_x} * {{MAH_X_W{1'b0}}, RCP_MAH};
  assign mah_steps = mah_recip[RCP_MAH_SH+QMAH_W-1:RCP_MAH_SH];
  assign mah_taken = {{DVSR_W{1'b0}}, dvd[QMAH_W-1:0]} * {{QMAH_W{1'b0}}, MAH_IN_UC};
  assign mah_left  = mag_m1 - DVD_W'(mah_taken);

  // Percent load divided by 100 through the reciprocal of 25
  assign ld_x     = product[LD_X_W+PCT_PRE_SH-1:PCT_PRE_SH];
  assign ld_recip = {{RCP_PCT_W{1'b0}}, ld_x} * {{LD_X_W{1'b0}}, RCP_PCT};
  assign ld_quot  = ld_recip[RCP_PCT_SH+QLD_W-1:RCP_PCT_SH];

  // Restoring divider for the percent, one quotient bit per step
  assign trial    = {rem[REM_W-2:0], dvd[DVD_W-1]};
  assign trial_ge = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= '0;
      unique case (cmd.div_sel)
        DIV_RESIDUE: begin
          dvd  <= DVD_W'(mah_steps);
          dvsr <= MAH_IN_UC;
        end
        DIV_LOAD: begin
          dvd  <= DVD_W'(ld_quot);
          dvsr <= PCT_SCALE;
        end
        DIV_PCT: begin
          dvd  <= DVD_W'(product);
          dvsr <= DVSR_W'(full_charge);
        end
        default: begin
          dvd  <= '0;
          dvsr <= MAH_IN_UC;
        end
      endcase
    end else if (cmd.rem_mah) begin
      rem <= REM_W'(mah_left);
    end else if (cmd.div_step) begin
      rem <= trial_ge ? (trial - {1'b0, dvsr}) : trial;
      dvd <= {dvd[DVD_W-2:0], trial_ge};
    end
  end

  // Whole mAh steps taken out of the residue
  assign rem_p1     = RES_W'(rem) + RES_W'(1);
  assign charge_sum = (DVD_W + 1)'(charge) + (DVD_W + 1)'(dvd);

  // Update charge and residue
  always_ff @(posedge clk) begin
    if (rst) begin
      charge  <= CHARGE_RESET;
      residue <= '0;
    end else if (cmd.apply_residue) begin
      if (res_zero) begin
        residue <= '0;
      end else begin
        if (res_neg) begin
          residue <= -$signed(rem_p1);
          charge  <= (|charge_sum[DVD_W:16]) ? CHARGE_MAX : charge_sum[15:0];
        end else begin
          residue <= $signed(rem_p1);
          charge  <= (dvd >= DVD_W'(charge)) ? 16'd0 : (charge - dvd[15:0]);
        end
      end
    end else if (cmd.apply_load) begin
      charge <= (|dvd[DVD_W-1:16]) ? CHARGE_MAX : dvd[15:0];
    end else if (cmd.apply_mah) begin
      charge <= new_charge;
    end
  end

  // Percent of full charge, saturated
  always_ff @(posedge clk) begin
    if (cmd.pct_full_zero) begin
      percent <= PERCENT_MAX;
    end else if (cmd.apply_pct) begin
      percent <= (|dvd[DVD_W-1:8]) ? PERCENT_MAX : dvd[7:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      out_data.charge_mah <= charge;
      out_data.percent    <= percent;
    end
  end

  assign status.func      = func;
  assign status.full_zero = (full_charge == 16'd0);
  assign status.out_busy  = out_valid && !out_ready;

endmodule

`default_nettype wire

>>> rtl/bcc_controller.sv
// Controller: sequences one item through multiplier, divider and updates.
`timescale 1ns / 1ps
`default_nettype none

module bcc_controller
  import bcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire bcc_status_t status,
  output bcc_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SMP_MUL,
    S_SMP_ADD,
    S_SMP_DIVLD,
    S_SMP_REM,
    S_SMP_APPLY,
    S_LD_MUL,
    S_LD_DIVLD,
    S_LD_APPLY,
    S_DIV,
    S_PCT,
    S_PCT_DIVLD,
    S_PCT_APPLY,
    S_OUT
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_sel = MUL_SAMPLE;
    cmd.div_sel = DIV_PCT;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.func)
          FUNC_SAMPLE:   state_next = S_SMP_MUL;
          FUNC_LOAD_MAH: begin
            cmd.apply_mah = 1'b1;
            state_next    = S_PCT;
          end
          FUNC_LOAD_PCT: state_next = S_LD_MUL;
          FUNC_NONE:     state_next = S_PCT;
          default:       state_next = S_PCT;
        endcase
      end
      S_SMP_MUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_SAMPLE;
        state_next  = S_SMP_ADD;
      end
      S_SMP_ADD: begin
        cmd.add_res = 1'b1;
        state_next  = S_SMP_DIVLD;
      end
      S_SMP_DIVLD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = DIV_RESIDUE;
        state_next   = S_SMP_REM;
      end
      S_SMP_REM: begin
        cmd.rem_mah = 1'b1;
        state_next  = S_SMP_APPLY;
      end
      S_SMP_APPLY: begin
        cmd.apply_residue = 1'b1;
        state_next        = S_PCT;
      end
      S_LD_MUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_LOAD;
        state_next  = S_LD_DIVLD;
      end
      S_LD_DIVLD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = DIV_LOAD;
        state_next   = S_LD_APPLY;
      end
      S_LD_APPLY: begin
        cmd.apply_load = 1'b1;
        state_next     = S_PCT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_PCT_APPLY;
        end
      end
      S_PCT: begin
        if (status.full_zero) begin
          cmd.pct_full_zero = 1'b1;
          state_next        = S_OUT;
        end else begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MUL_PCT;
          state_next  = S_PCT_DIVLD;
        end
      end
      S_PCT_DIVLD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = DIV_PCT;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_PCT_APPLY: begin
        cmd.apply_pct = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!status.out_busy) begin
          cmd.out_write = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

`default_nettype wire

>>> rtl/battery_coulomb_counter_top.sv
// Top level of the battery coulomb counter.
`timescale 1ns / 1ps
`default_nettype none

// Coulomb counter with state of charge. Each input transfer yields one output
// transfer carrying the charge in mAh and its percentage of full charge. One
// item is worked at a time. A shared 17x17 multiplier forms the sample charge
// and the percent products; the fixed divisions by one mAh in uC and by 100
// use reciprocal multiplications, and the percent of full charge uses a
// restoring divider (34 steps, one quotient bit per cycle), which sets most of
// the rate. With zero full charge the percent multiply and divide are skipped
// and the percent saturates. The output register lets the next item be taken
// while a result still waits; a result is written only once the register is
// free. Configuration writes are taken in any cycle.
module battery_coulomb_counter_top
  import bcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire bcc_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output bcc_out_t                  out_data,
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  bcc_cmd_t    cmd;
  bcc_status_t status;

  bcc_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bcc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_data      (in_data),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

`default_nettype wire

>>> rtl/bcc_checker.sv
// Port-level checker for the battery coulomb counter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bcc_checker
  import bcc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire bcc_out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One item at a time: no accept right after a transfer in
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");

  // A new result is produced only by a busy block
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared from idle");

  // Empty pack reads zero percent, or saturated with zero full charge
  a_empty_pct: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.charge_mah != 16'd0 || out_data.percent == 8'd0 ||
                   out_data.percent == PERCENT_MAX))
    else $error("bad percent for empty pack");

endmodule

bind battery_coulomb_counter_top bcc_checker u_chk (.*);

`default_nettype wire
